/* rtl/pcc_pkg.sv */
// pcc_pkg: widths, register indexes and result type of the pwm capture checker
// shared by the pwm_capture_checker top level and its bound checker
// no dependencies
`default_nettype none

package pcc_pkg;

    // field widths
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned FREQ_W    = 32;
    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;

    // stream bus widths (fields packed from bit 0, padded to whole bytes)
    localparam int unsigned S_TDATA_W = 2 * COUNT_W;
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_USED_W  = FREQ_W + DUTY_W + 1;

    // permille scale and the width of high_count times the scale
    localparam int unsigned PERMILLE_SCALE = 1000;
    localparam int unsigned PROD_W         = COUNT_W + DUTY_W;

    // one quotient bit per division stage
    localparam int unsigned DIV_STAGES = FREQ_W;

    // register reset values
    localparam logic [CFG_W-1:0] TICK_RATE_RESET = CFG_W'(1000000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_FREQ  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_DUTY  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_TOL  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_TOL  = CFG_IDX_W'(4);

    // one result item
    typedef struct packed {
        logic              within_tolerance;
        logic [DUTY_W-1:0] measured_duty;
        logic [FREQ_W-1:0] measured_frequency;
        logic              status;
    } t_result;

endpackage

`default_nettype wire

/* rtl/pwm_capture_checker.sv */
// pwm_capture_checker: pipelined pwm frequency and duty measurement check
// depends on pcc_pkg; pcc_checker is bound to it from its own file
//
// usage
//   slave stream: one capture per transaction, tdata = period_count (bits 31:0),
//   high_count (bits 63:32). master stream: one result per capture, tuser = status
//   (1 = invalid capture), tdata = measured_frequency, measured_duty,
//   within_tolerance, zero padded to 48 bits.
//   configuration: a write at every edge with i_cfg_wr_en high; index 0 tick rate,
//   1 commanded frequency, 2 commanded duty, 3 frequency tolerance, 4 duty
//   tolerance; other indexes are ignored. write only while the pipeline is empty.
//   throughput: one capture per cycle while o_s_tready is high. pipeline: input stage,
//   then the 32 restoring-division stages (one quotient bit each, duty quotient in
//   the first ten), the deviation stage and the output register.
//   reset: synchronous, clears all valid bits and loads register reset values.
//   stall: an output register plus one skid entry; when the receiver holds off,
//   one further result lands in the skid entry, then o_s_tready drops and the
//   whole pipeline holds its contents until the skid entry drains.
`default_nettype none

module pwm_capture_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // capture stream: period_count, high_count
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    input  wire  [pcc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // result stream: measured_frequency, measured_duty, within_tolerance
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [pcc_pkg::M_TDATA_W-1:0] o_m_tdata,
    // status
    output logic                         o_m_tuser,
    // configuration write port
    input  wire                          i_cfg_wr_en,
    input  wire  [pcc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire  [pcc_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import pcc_pkg::*;

    // configuration registers
    logic [FREQ_W-1:0]  r_tick_rate;
    logic [FREQ_W-1:0]  r_cmd_freq;
    logic [DUTY_W-1:0]  r_cmd_duty;
    logic [FREQ_W-1:0]  r_freq_tol;
    logic [DUTY_W-1:0]  r_duty_tol;

    // division pipeline, entry 0 is the input stage
    logic               r_v    [0:DIV_STAGES];
    logic               r_inv  [0:DIV_STAGES];
    logic [COUNT_W-1:0] r_d    [0:DIV_STAGES];
    logic [FREQ_W-1:0]  r_frem [0:DIV_STAGES];
    logic [FREQ_W-1:0]  r_fq   [0:DIV_STAGES];
    logic [COUNT_W-1:0] r_drem [0:DIV_STAGES];
    logic [DUTY_W-1:0]  r_dq   [0:DIV_STAGES];

    logic [COUNT_W-1:0] n_frem [1:DIV_STAGES];
    logic [FREQ_W-1:0]  n_fq   [1:DIV_STAGES];
    logic [COUNT_W-1:0] n_drem [1:DIV_STAGES];
    logic [DUTY_W-1:0]  n_dq   [1:DIV_STAGES];

    // deviation stage
    logic               r_dv;
    logic               r_dinv;
    logic [FREQ_W-1:0]  r_dfreq;
    logic [DUTY_W-1:0]  r_dduty;
    logic [FREQ_W-1:0]  r_fdiff;
    logic [DUTY_W-1:0]  r_ddiff;
    logic [FREQ_W-1:0]  n_fdiff;
    logic [DUTY_W-1:0]  n_ddiff;

    // output register and skid entry
    logic               r_out_valid;
    t_result            r_out;
    logic               r_skid_valid;
    t_result            r_skid;

    logic               w_adv;
    logic               w_take;
    logic               w_out_free;
    logic [COUNT_W-1:0] w_period;
    logic [COUNT_W-1:0] w_high;
    logic               w_inv;
    logic [PROD_W-1:0]  w_prod;
    t_result            w_res;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RESET;
            r_cmd_freq  <= '0;
            r_cmd_duty  <= '0;
            r_freq_tol  <= '0;
            r_duty_tol  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_TICK_RATE: r_tick_rate <= i_cfg_wdata[FREQ_W-1:0];
                CFG_CMD_FREQ:  r_cmd_freq  <= i_cfg_wdata[FREQ_W-1:0];
                CFG_CMD_DUTY:  r_cmd_duty  <= i_cfg_wdata[DUTY_W-1:0];
                CFG_FREQ_TOL:  r_freq_tol  <= i_cfg_wdata[FREQ_W-1:0];
                CFG_DUTY_TOL:  r_duty_tol  <= i_cfg_wdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline moves as a whole while the skid entry is empty
    assign w_adv      = !r_skid_valid;
    assign o_s_tready = w_adv;

    // input decode, validity check and permille product
    assign w_period = i_s_tdata[COUNT_W-1:0];
    assign w_high   = i_s_tdata[2*COUNT_W-1:COUNT_W];
    assign w_inv    = (w_period == '0) || (w_high > w_period) || (r_tick_rate == '0);
    assign w_prod   = PROD_W'(w_high) * PROD_W'(PERMILLE_SCALE);

    // one restoring-division step per stage; the duty quotient is below 1024
    // for a valid capture, so its remainder starts from the product's top bits
    always_comb begin
        logic [COUNT_W:0] t_f;
        logic [COUNT_W:0] t_d;
        logic             ge_f;
        logic             ge_d;
        for (int k = 0; k < DIV_STAGES; k++) begin
            t_f  = {r_frem[k], r_fq[k][FREQ_W-1]};
            ge_f = t_f >= {1'b0, r_d[k]};
            n_frem[k+1] = ge_f ? COUNT_W'(t_f - {1'b0, r_d[k]}) : t_f[COUNT_W-1:0];
            n_fq[k+1]   = {r_fq[k][FREQ_W-2:0], ge_f};
            if (k < DUTY_W) begin
                t_d  = {r_drem[k], r_dq[k][DUTY_W-1]};
                ge_d = t_d >= {1'b0, r_d[k]};
                n_drem[k+1] = ge_d ? COUNT_W'(t_d - {1'b0, r_d[k]}) : t_d[COUNT_W-1:0];
                n_dq[k+1]   = {r_dq[k][DUTY_W-2:0], ge_d};
            end else begin
                n_drem[k+1] = r_drem[k];
                n_dq[k+1]   = r_dq[k];
            end
        end
    end

    // division pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_s_tvalid;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // division pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_inv[0]  <= w_inv;
            r_d[0]    <= w_period;
            r_frem[0] <= '0;
            r_fq[0]   <= r_tick_rate;
            r_drem[0] <= w_prod[PROD_W-1:DUTY_W];
            r_dq[0]   <= w_prod[DUTY_W-1:0];
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_inv[k]  <= r_inv[k-1];
                r_d[k]    <= r_d[k-1];
                r_frem[k] <= n_frem[k];
                r_fq[k]   <= n_fq[k];
                r_drem[k] <= n_drem[k];
                r_dq[k]   <= n_dq[k];
            end
        end
    end

    // absolute deviations from the commanded values
    always_comb begin
        n_fdiff = (r_cmd_freq >= r_fq[DIV_STAGES]) ? r_cmd_freq - r_fq[DIV_STAGES]
                                                   : r_fq[DIV_STAGES] - r_cmd_freq;
        n_ddiff = (r_cmd_duty >= r_dq[DIV_STAGES]) ? r_cmd_duty - r_dq[DIV_STAGES]
                                                   : r_dq[DIV_STAGES] - r_cmd_duty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (w_adv) begin
            r_dv <= r_v[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dinv  <= r_inv[DIV_STAGES];
            r_dfreq <= r_fq[DIV_STAGES];
            r_dduty <= r_dq[DIV_STAGES];
            r_fdiff <= n_fdiff;
            r_ddiff <= n_ddiff;
        end
    end

    // tolerance compare and zeroing of invalid captures
    always_comb begin
        w_res.status             = r_dinv;
        w_res.measured_frequency = r_dinv ? '0 : r_dfreq;
        w_res.measured_duty      = r_dinv ? '0 : r_dduty;
        w_res.within_tolerance   = !r_dinv && (r_fdiff <= r_freq_tol)
                                           && (r_ddiff <= r_duty_tol);
    end

    // output register with one skid entry
    assign w_take     = w_adv && r_dv;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_take;
            end
        end else if (w_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_take) begin
                r_out <= w_res;
            end
        end else if (w_take) begin
            r_skid <= w_res;
        end
    end

    // result transaction
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {(M_TDATA_W - M_USED_W)'(0), r_out.within_tolerance,
                         r_out.measured_duty, r_out.measured_frequency};

endmodule

`default_nettype wire

/* rtl/pcc_checker.sv */
// pcc_checker: port-level assertions for pwm_capture_checker, bound to the top level
// depends on pcc_pkg and on the port names of pwm_capture_checker
`default_nettype none

module pcc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_s_tready,
    input wire                          o_m_tvalid,
    input wire                          i_m_tready,
    input wire [pcc_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire                          o_m_tuser
);
    import pcc_pkg::*;

    // a stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // an invalid capture carries all-zero result fields
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("invalid capture with nonzero fields");

    // a valid measurement never exceeds full duty
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |->
            o_m_tdata[FREQ_W+DUTY_W-1:FREQ_W] <= DUTY_W'(PERMILLE_SCALE))
        else $error("duty above full scale");

    // back-pressure on the capture side only while a result is pending
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("capture side stalled with no pending result");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind pwm_capture_checker pcc_checker u_pcc_checker (.*);

`default_nettype wire
